/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, muted while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/u8d_pkg.sv */
package u8d_pkg;

  localparam int unsigned CpW    = 31;
  localparam int unsigned LenW   = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  // Work handed from the front end to the back end for one byte.
  typedef struct packed {
    logic [LenW-1:0] n_inv;  // invalid results to give first
    logic            fin;    // a closing result follows the invalid ones
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
  } u8d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u8d_q_stat_t;

endpackage

/* hw/rtl/u8d_front.sv */
module u8d_front
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  u8d_q_stat_t q_stat,
  output logic        push,
  output u8d_job_t    job
);

  logic [CpW-1:0]  acc_r, acc_nxt;
  logic [LenW-1:0] exp_r, exp_nxt;
  logic [LenW-1:0] held_r, held_nxt;
  logic            has_job;
  logic            take;
  logic [LenW-1:0] held_inc;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign held_inc = held_r + LenW'(1);
  assign push     = take && has_job;

  always_comb begin
    acc_nxt   = acc_r;
    exp_nxt   = exp_r;
    held_nxt  = held_r;
    job.n_inv = '0;
    job.fin   = 1'b0;
    job.cp    = '0;
    job.len   = '0;
    if ((exp_r != '0) && (in_byte_in[7:6] == 2'b10)) begin
      // extend the pending sequence
      acc_nxt  = {acc_r[CpW-7:0], in_byte_in[5:0]};
      held_nxt = held_inc;
      if (held_inc >= exp_r) begin
        job.fin  = 1'b1;
        job.cp   = acc_nxt;
        job.len  = exp_r;
        acc_nxt  = '0;
        exp_nxt  = '0;
        held_nxt = '0;
      end
    end else begin
      // flush whatever is held, then decode the byte as a fresh start
      if (exp_r != '0) begin
        job.n_inv = held_r;
      end
      acc_nxt  = '0;
      exp_nxt  = '0;
      held_nxt = '0;
      case (in_byte_in) inside
        [8'h00:8'h7F]: begin
          job.fin = 1'b1;
          job.cp  = CpW'(in_byte_in);
          job.len = (in_byte_in != 8'h00) ? LenW'(1) : LenW'(0);
        end
        [8'h80:8'hBF]: begin
          job.n_inv = LenW'(1);
        end
        [8'hC0:8'hDF]: begin
          acc_nxt = CpW'(in_byte_in & 8'h1F);
          exp_nxt = LenW'(2);
        end
        [8'hE0:8'hEF]: begin
          acc_nxt = CpW'(in_byte_in & 8'h0F);
          exp_nxt = LenW'(3);
        end
        [8'hF0:8'hF7]: begin
          acc_nxt = CpW'(in_byte_in & 8'h07);
          exp_nxt = LenW'(4);
        end
        [8'hF8:8'hFB]: begin
          acc_nxt = CpW'(in_byte_in & 8'h07);
          exp_nxt = LenW'(5);
        end
        default: begin
          acc_nxt = CpW'(in_byte_in & 8'h01);
          exp_nxt = LenW'(6);
        end
      endcase
      if (exp_nxt != '0) begin
        held_nxt = LenW'(1);
      end
    end
  end

  assign has_job = job.fin || (job.n_inv != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      exp_r  <= '0;
      held_r <= '0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* hw/rtl/u8d_queue.sv */
module u8d_queue
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  u8d_job_t    wr_job,
  input  logic        pop,
  output u8d_job_t    rd_job,
  output u8d_q_stat_t stat
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  u8d_job_t         mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/u8d_back.sv */
module u8d_back
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  u8d_job_t        job,
  input  logic            job_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_invalid,
  output logic [LenW-1:0] out_seq_length,
  output logic            out_last
);

  logic            busy_r;
  logic [LenW-1:0] inv_left_r;
  logic            fin_r;
  logic [CpW-1:0]  cp_r;
  logic [LenW-1:0] len_r;
  logic            xfer;
  logic            on_inv;

  assign on_inv         = (inv_left_r != '0);
  assign out_valid      = busy_r;
  assign out_invalid    = on_inv;
  assign out_code_point = on_inv ? '0 : cp_r;
  assign out_seq_length = on_inv ? '0 : len_r;
  assign out_last       = on_inv ? ((inv_left_r == LenW'(1)) && !fin_r) : 1'b1;
  assign xfer           = out_valid && out_ready;
  // load the next job as soon as the current one has given its last result
  assign pop            = job_valid && (!busy_r || (xfer && out_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      fin_r <= job.fin;
      cp_r  <= job.cp;
      len_r <= job.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      inv_left_r <= '0;
    end else if (pop) begin
      busy_r     <= 1'b1;
      inv_left_r <= job.n_inv;
    end else if (xfer) begin
      if (out_last) begin
        busy_r     <= 1'b0;
        inv_left_r <= '0;
      end else begin
        inv_left_r <= inv_left_r - LenW'(1);
      end
    end
  end

endmodule

/* hw/rtl/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder, legacy 5- and 6-byte forms included. Bytes enter on
// in_* at one per cycle and code points leave on out_*. A byte that gives at
// most one result (ASCII, end of text, lead, continuation, stray
// continuation) uses out_* at most once. A byte that breaks a pending
// sequence gives one invalid result per held byte, then its own result if
// any, up to six in all; the result port gives one result per cycle while
// out_ready is high, and input stalls once the two-entry job queue between
// the classifying front end and the result back end is full. out_last marks
// the final result caused by each byte. Lead bytes give no result.
`include "assert_macros.svh"

module utf8_stream_decoder_unit
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_invalid,
  output logic [LenW-1:0] out_seq_length,
  output logic            out_last
);

  u8d_job_t    push_job, pop_job;
  u8d_q_stat_t q_stat;
  logic        push, pop;

  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .q_stat     (q_stat),
    .push       (push),
    .job        (push_job)
  );

  u8d_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (pop_job),
    .job_valid      (!q_stat.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_invalid    (out_invalid),
    .out_seq_length (out_seq_length),
    .out_last       (out_last)
  );

  `ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_stat.full, "job queue overflow")
  `ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !q_stat.empty, "job queue underflow")
  `ASSERT_IMP(a_inv_zero, clk, rst_n, out_valid && out_invalid, (out_code_point == '0) && (out_seq_length == '0), "invalid result carries data")
  `ASSERT_IMP(a_good_last, clk, rst_n, out_valid && !out_invalid, out_last, "decoded result not marked last")

endmodule

/* verif/utf8_stream_decoder_unit_tb.sv */
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_tb
  import u8d_pkg::*;
();

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic            inv;
    logic [LenW-1:0] len;
    logic            last;
  } cp_result_t;

  // One row of the directed stream; has_res marks a hand-written result.
  typedef struct packed {
    logic [7:0] data;
    logic       has_res;
    cp_result_t res;
  } stim_row_t;

  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] LEAD2_BASE  = 8'hC0;
  localparam logic [7:0] LEAD3_BASE  = 8'hE0;
  localparam logic [7:0] LEAD4_BASE  = 8'hF0;
  localparam logic [7:0] LEAD5_BASE  = 8'hF8;
  localparam logic [7:0] LEAD6_BASE  = 8'hFC;
  localparam logic [7:0] END_OF_TEXT = 8'h00;

  localparam int N_RANDOM   = 280;
  localparam int HOLD_OFF   = 300;
  localparam int WATCHDOG   = 3000;
  localparam int DRAIN_WAIT = 20;

  localparam cp_result_t NO_RES  = '0;
  localparam cp_result_t DROPPED = '{cp: '0, inv: 1'b1, len: '0, last: 1'b0};

  localparam stim_row_t DIR_TAB [0:26] = '{
    '{8'h00, 1'b1, '{31'h0, 1'b0, 3'd0, 1'b1}},
    '{8'h7F, 1'b1, '{31'h7F, 1'b0, 3'd1, 1'b1}},
    '{8'h80, 1'b1, '{31'h0, 1'b1, 3'd0, 1'b1}},
    '{8'hBF, 1'b1, '{31'h0, 1'b1, 3'd0, 1'b1}},
    // lead broken by a lead, then an overlong two-byte zero
    '{8'hC0, 1'b0, NO_RES},
    '{8'hC0, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    // three-byte sequence cut short by ASCII
    '{8'hE2, 1'b0, NO_RES},
    '{8'h82, 1'b0, NO_RES},
    '{8'h41, 1'b0, NO_RES},
    '{8'hF8, 1'b0, NO_RES},
    '{8'h88, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    // six-byte form with every payload bit set
    '{8'hFD, 1'b0, NO_RES},
    '{8'hBF, 1'b0, NO_RES},
    '{8'hBF, 1'b0, NO_RES},
    '{8'hBF, 1'b0, NO_RES},
    '{8'hBF, 1'b0, NO_RES},
    '{8'hBF, 1'b1, '{31'h7FFF_FFFF, 1'b0, 3'd6, 1'b1}},
    // five bytes held, then end of text: six results from one byte
    '{8'hFF, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}
  };

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte_in;
  logic            out_valid;
  logic            out_ready;
  logic [CpW-1:0]  out_code_point;
  logic            out_invalid;
  logic [LenW-1:0] out_seq_length;
  logic            out_last;

  // Travels with the byte on the input side
  logic       row_has_res;
  cp_result_t row_res;

  // Decoder state mirror
  logic [CpW-1:0]  acc_bits;
  logic [LenW-1:0] pend_len;
  logic [LenW-1:0] held_n;

  cp_result_t byte_results[$];
  cp_result_t due_results[$];

  int errors        = 0;
  int bytes_seen    = 0;
  int results_seen  = 0;
  int dropped_seen  = 0;
  int most_per_byte = 0;
  int quiet_cycles  = 0;
  int sent_bytes    = 0;
  bit tx_burst      = 1'b0;

  utf8_stream_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_invalid    (out_invalid),
    .out_seq_length (out_seq_length),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the results one byte causes and advance the state mirror.
  function automatic void decode_byte(input logic [7:0] b);
    cp_result_t tail;
    logic [7:0] mask;
    if (pend_len != 0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        acc_bits = {acc_bits[CpW-7:0], b[5:0]};
        held_n   = held_n + 1'b1;
        if (held_n >= pend_len) begin
          byte_results.push_back('{cp: acc_bits, inv: 1'b0, len: pend_len, last: 1'b1});
          acc_bits = '0;
          pend_len = '0;
          held_n   = '0;
        end
        return;
      end
      // flush every held byte before taking this one afresh
      repeat (held_n) byte_results.push_back(DROPPED);
      acc_bits = '0;
      pend_len = '0;
      held_n   = '0;
    end
    if (b < CONT_TAG) begin
      byte_results.push_back('{cp: CpW'(b), inv: 1'b0,
                               len: (b != END_OF_TEXT) ? LenW'(1) : LenW'(0),
                               last: 1'b0});
    end else if (b < LEAD2_BASE) begin
      byte_results.push_back(DROPPED);
    end else begin
      if (b < LEAD3_BASE) begin
        pend_len = 3'd2;
        mask     = 8'h1F;
      end else if (b < LEAD4_BASE) begin
        pend_len = 3'd3;
        mask     = 8'h0F;
      end else if (b < LEAD5_BASE) begin
        pend_len = 3'd4;
        mask     = 8'h07;
      end else if (b < LEAD6_BASE) begin
        pend_len = 3'd5;
        mask     = 8'h07;
      end else begin
        pend_len = 3'd6;
        mask     = 8'h01;
      end
      acc_bits = CpW'(b & mask);
      held_n   = 3'd1;
    end
    if (byte_results.size() > 0) begin
      tail      = byte_results.pop_back();
      tail.last = 1'b1;
      byte_results.push_back(tail);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic has_res, input cp_result_t res);
    int gap;
    if (sent_bytes % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_in  <= b;
    row_has_res <= has_res;
    row_res     <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Predict on input transfers, check on output transfers, watch for a hang.
  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        byte_results.delete();
        decode_byte(in_byte_in);
        if (row_has_res) due_results.push_back(row_res);
        else foreach (byte_results[i]) due_results.push_back(byte_results[i]);
        bytes_seen++;
        if (byte_results.size() > most_per_byte) most_per_byte = byte_results.size();
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (out_invalid) dropped_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result cp %h inv %b len %0d last %b", $time,
                   out_code_point, out_invalid, out_seq_length, out_last);
        end else begin
          want = due_results.pop_front();
          if (out_code_point !== want.cp) begin
            errors++;
            $display("%0t: code_point expected %h actual %h", $time, want.cp, out_code_point);
          end
          if (out_invalid !== want.inv) begin
            errors++;
            $display("%0t: invalid expected %b actual %b", $time, want.inv, out_invalid);
          end
          if (out_seq_length !== want.len) begin
            errors++;
            $display("%0t: seq_length expected %0d actual %0d", $time, want.len,
                     out_seq_length);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, out_last);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, due_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, bursts of constant ready, one long hold-off.
  initial begin
    int gap;
    int taken;
    bit burst;
    bit held_off;
    out_ready = 1'b0;
    taken     = 0;
    burst     = 1'b0;
    held_off  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 19);
      if (!held_off && results_seen >= 40) begin
        held_off = 1'b1;
        gap      = HOLD_OFF;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    logic [7:0] stream[$];
    logic [7:0] b;
    int pick;
    int len;
    int n_cont;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte_in  = 8'h00;
    row_has_res = 1'b0;
    row_res     = NO_RES;
    acc_bits    = '0;
    pend_len    = '0;
    held_n      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) send_byte(DIR_TAB[i].data, DIR_TAB[i].has_res, DIR_TAB[i].res);

    // Mostly well-formed sequences; some cut short, some raw noise.
    while (stream.size() < N_RANDOM) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 7) ? $urandom_range(1, 6) : $urandom_range(2, 6);
      if (pick == 9) begin
        stream.push_back(($urandom_range(0, 1) == 0) ? END_OF_TEXT : 8'($urandom_range(0, 255)));
      end else begin
        case (len)
          1:       b = 8'($urandom_range(0, 127));
          2:       b = 8'($urandom_range(8'hC0, 8'hDF));
          3:       b = 8'($urandom_range(8'hE0, 8'hEF));
          4:       b = 8'($urandom_range(8'hF0, 8'hF7));
          5:       b = 8'($urandom_range(8'hF8, 8'hFB));
          default: b = 8'($urandom_range(8'hFC, 8'hFF));
        endcase
        stream.push_back(b);
        n_cont = (pick < 7) ? len - 1 : $urandom_range(0, len - 2);
        repeat (n_cont) stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
        if (pick >= 7) begin
          // break the sequence with anything but a continuation
          do b = 8'($urandom_range(0, 255)); while ((b & CONT_MASK) == CONT_TAG);
          stream.push_back(b);
        end
      end
    end
    foreach (stream[i]) send_byte(stream[i], 1'b0, NO_RES);
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("decoded %0d bytes (%0d directed, %0d random) into %0d results", bytes_seen,
             $size(DIR_TAB), stream.size(), results_seen);
    $display("%0d dropped-byte results, up to %0d results from one byte, %0d mismatches",
             dropped_seen, most_per_byte, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
